>>> hw/rtl/pob_pkg.sv
`default_nettype none
package pob_pkg;

    localparam int PIX_W      = 8;
    localparam int WEIGHT_W   = 16;
    localparam int CC_W       = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int COLORS     = 3;
    // alpha numerator da*(65535-w) + sa*w stays below 2^24
    localparam int NUM_W      = 24;
    // rounded color dividend p + num/2
    localparam int REM_W      = 33;
    // divisor pre-shifted to the top quotient bit
    localparam int DVS_W      = NUM_W + PIX_W - 1;
    // one cell per quotient bit; quotient never exceeds 255
    localparam int DIV_STEPS  = PIX_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = '1;
    localparam logic [WEIGHT_W-1:0] ALPHA_ROUND = WEIGHT_MAX >> 1;
    localparam logic [PIX_W-1:0]    FULL_PIX    = '1;
    localparam logic [CC_W-1:0]     CC_ALPHA    = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EFFECT_WEIGHT = 1'b0,
        REG_CHANNEL_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] src_red;
        logic [PIX_W-1:0] src_green;
        logic [PIX_W-1:0] src_blue;
        logic [PIX_W-1:0] src_alpha;
        logic [PIX_W-1:0] dst_red;
        logic [PIX_W-1:0] dst_green;
        logic [PIX_W-1:0] dst_blue;
        logic [PIX_W-1:0] dst_alpha;
    } pob_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_alpha;
    } pob_out_t;

    // one pixel in flight through the divider chain
    typedef struct packed {
        logic [COLORS-1:0]             bypass;
        logic [COLORS-1:0][PIX_W-1:0]  fixed;
        logic [PIX_W-1:0]              alpha;
        logic [NUM_W-1:0]              num;
        logic [DVS_W-1:0]              dvs;
        logic [COLORS-1:0][REM_W-1:0]  rem;
        logic [COLORS-1:0][PIX_W-1:0]  quo;
    } div_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/pob_front.sv
`default_nettype none
module pob_front
    import pob_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [WEIGHT_W-1:0] weight,
    input  wire logic [CC_W-1:0]     channel_count,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire pob_in_t             up_pixel,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output div_item_t                dn_item
);

    typedef struct packed {
        logic [COLORS-1:0][PIX_W-1:0]   src;
        logic [COLORS-1:0][PIX_W-1:0]   dst;
        logic [PIX_W-1:0]               sa;
        logic [PIX_W-1:0]               da;
        logic [WEIGHT_W-1:0]            w;
        logic [WEIGHT_W-1:0]            bw;
        logic                           alpha_on;
        logic [COLORS-1:0]              used;
        logic [COLORS-1:0][2*PIX_W-1:0] dda;
        logic [COLORS-1:0][2*PIX_W-1:0] ssa;
        logic [NUM_W-1:0]               da_bw;
        logic [NUM_W-1:0]               sa_w;
    } mul_stage_t;

    logic       a_valid_reg, a_valid_next;
    logic       b_valid_reg, b_valid_next;
    logic       a_ready, b_ready;
    mul_stage_t a_reg, a_next;
    div_item_t  b_reg, b_next;

    // stage A: alpha selection and first products
    always_comb
    begin
        a_next.src      = {up_pixel.src_blue, up_pixel.src_green, up_pixel.src_red};
        a_next.dst      = {up_pixel.dst_blue, up_pixel.dst_green, up_pixel.dst_red};
        a_next.alpha_on = (channel_count >= CC_ALPHA);
        a_next.sa       = a_next.alpha_on ? up_pixel.src_alpha : FULL_PIX;
        a_next.da       = a_next.alpha_on ? up_pixel.dst_alpha : FULL_PIX;
        a_next.w        = weight;
        a_next.bw       = WEIGHT_MAX - weight;
        for (int c = 0; c < COLORS; c++)
        begin
            a_next.used[c] = (channel_count > CC_W'(c));
            a_next.dda[c]  = a_next.dst[c] * a_next.da;
            a_next.ssa[c]  = a_next.src[c] * a_next.sa;
        end
        a_next.da_bw = a_next.da * a_next.bw;
        a_next.sa_w  = a_next.sa * a_next.w;
    end

    // stage B: weighted sums, numerator, rounded dividend, special cases, alpha
    logic [NUM_W:0]   num_sum;
    logic [NUM_W-1:0] num;
    logic [NUM_W:0]   ax;
    logic [PIX_W:0]   aq0;
    logic [WEIGHT_W:0] ar;
    logic [PIX_W:0]   aq;
    logic             w_zero, w_full, num_zero;
    logic [REM_W-1:0] p_sum;

    always_comb
    begin
        num_sum  = {1'b0, a_reg.da_bw} + {1'b0, a_reg.sa_w};
        num      = num_sum[NUM_W-1:0];
        w_zero   = (a_reg.w == '0);
        w_full   = (a_reg.w == WEIGHT_MAX);
        num_zero = (num == '0);

        // divide by 65535: quotient estimate x>>16, one correction step
        ax  = {1'b0, num} + {{(NUM_W+1-WEIGHT_W){1'b0}}, ALPHA_ROUND};
        aq0 = ax[NUM_W:WEIGHT_W];
        ar  = {1'b0, ax[WEIGHT_W-1:0]} + {{(WEIGHT_W-PIX_W){1'b0}}, aq0};
        aq  = aq0 + {{PIX_W{1'b0}}, (ar >= {1'b0, WEIGHT_MAX})};

        b_next.num = num;
        b_next.dvs = {num, {(PIX_W-1){1'b0}}};
        for (int c = 0; c < COLORS; c++)
        begin
            p_sum = REM_W'(a_reg.dda[c]) * REM_W'(a_reg.bw)
                  + REM_W'(a_reg.ssa[c]) * REM_W'(a_reg.w);
            b_next.rem[c]    = p_sum + REM_W'(num >> 1);
            b_next.quo[c]    = '0;
            b_next.bypass[c] = !a_reg.used[c] || w_zero || w_full || num_zero;
            if (!a_reg.used[c] || w_zero)
                b_next.fixed[c] = a_reg.dst[c];
            else if (w_full)
                b_next.fixed[c] = a_reg.src[c];
            else
                b_next.fixed[c] = '0;
        end

        if (!a_reg.alpha_on)
            b_next.alpha = FULL_PIX;
        else if (w_zero)
            b_next.alpha = a_reg.da;
        else if (w_full)
            b_next.alpha = a_reg.sa;
        else
            b_next.alpha = aq[PIX_W-1:0];
    end

    assign b_ready  = !b_valid_reg || dn_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;
    assign dn_valid = b_valid_reg;
    assign dn_item  = b_reg;

    always_comb
    begin
        a_valid_next = a_ready ? up_valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && a_ready)
            a_reg <= a_next;
        if (a_valid_reg && b_ready)
            b_reg <= b_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/pob_div_cell.sv
`default_nettype none
module pob_div_cell
    import pob_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire div_item_t up_item,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output div_item_t      dn_item
);

    logic      valid_reg, valid_next;
    div_item_t item_reg, item_next;
    logic [REM_W-1:0] dvs_ext;
    logic             take;

    // one restoring step: subtract the shifted divisor where it fits, shift in the bit
    always_comb
    begin
        item_next = up_item;
        dvs_ext   = {{(REM_W-DVS_W){1'b0}}, up_item.dvs};
        for (int c = 0; c < COLORS; c++)
        begin
            take = (up_item.rem[c] >= dvs_ext);
            if (take)
                item_next.rem[c] = up_item.rem[c] - dvs_ext;
            item_next.quo[c] = {up_item.quo[c][PIX_W-2:0], take};
        end
        item_next.dvs = up_item.dvs >> 1;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;
    assign dn_valid   = valid_reg;
    assign dn_item    = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            item_reg <= item_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/premultiplied_opacity_blend.sv
`default_nettype none
// Pipeline: two multiply stages, eight divider cells and one output
//   register lie between an input transfer and its result being offered.
// Throughput: one pixel per cycle unless out_stall holds the pipeline.
// Reset (rst_n low, asynchronous): pipeline emptied, blend weight = 0,
//   channel count = 4.
module premultiplied_opacity_blend
    import pob_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire pob_in_t               in_pixel,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output pob_out_t                   out_pixel
);

    // Configuration registers; the user must write them only while the pipeline is empty, unchecked by the block.
    logic [WEIGHT_W-1:0] weight_reg;
    logic [CC_W-1:0]     ccount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            ccount_reg <= CC_ALPHA;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_EFFECT_WEIGHT: weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_CHANNEL_COUNT: ccount_reg <= cfg_data[CC_W-1:0];
                default:           ;
            endcase
        end
    end

    // Chain position 0 is the front end; positions 1..DIV_STEPS are the
    // divider cells, each resolving one quotient bit, MSB first.
    logic      chain_valid [DIV_STEPS+1];
    logic      chain_ready [DIV_STEPS+1];
    div_item_t chain_item  [DIV_STEPS+1];
    logic      front_ready;

    pob_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .weight        (weight_reg),
        .channel_count (ccount_reg),
        .up_valid      (in_valid),
        .up_ready      (front_ready),
        .up_pixel      (in_pixel),
        .dn_valid      (chain_valid[0]),
        .dn_ready      (chain_ready[0]),
        .dn_item       (chain_item[0])
    );

    // stall the input only when the front stages are full and cannot advance
    assign in_stall = !front_ready;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        pob_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_item  (chain_item[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_item  (chain_item[i+1])
        );
    end

    // Output register: parts the chain from the consumer, so the chain keeps
    // filling bubbles while a finished pixel waits.
    logic      out_valid_reg, out_valid_next;
    pob_out_t  out_reg, out_next;
    logic      out_ready;
    div_item_t last_item;
    logic [COLORS-1:0][PIX_W-1:0] color;

    assign last_item = chain_item[DIV_STEPS];
    assign out_ready = !out_valid_reg || !out_stall;
    assign chain_ready[DIV_STEPS] = out_ready;

    // pick the quotient or the pass-through value for each channel
    always_comb
    begin
        for (int c = 0; c < COLORS; c++)
            color[c] = last_item.bypass[c] ? last_item.fixed[c] : last_item.quo[c];
        out_next.out_red   = color[0];
        out_next.out_green = color[1];
        out_next.out_blue  = color[2];
        out_next.out_alpha = last_item.alpha;
        out_valid_next     = out_ready ? chain_valid[DIV_STEPS] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[DIV_STEPS] && out_ready)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_reg;

`ifndef SYNTHESIS
    logic [REM_W-1:0] last_num_ext;
    assign last_num_ext = {{(REM_W-NUM_W){1'b0}}, last_item.num};

    // after the last cell every remainder must be below the divisor
    a_rem_below_num: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[DIV_STEPS] && (last_item.num != '0) |->
            (last_item.rem[0] < last_num_ext) && (last_item.rem[1] < last_num_ext)
            && (last_item.rem[2] < last_num_ext))
        else $error("divider remainder not reduced below numerator");

    // a zero numerator must never reach the output through the quotient path
    a_zero_num_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[DIV_STEPS] && (last_item.num == '0) |-> (&last_item.bypass))
        else $error("zero alpha numerator not bypassed");

    // the last divider cell, holding a pixel that cannot move, keeps it
    a_last_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[DIV_STEPS] && !out_ready |=>
            chain_valid[DIV_STEPS] && $stable(last_item))
        else $error("last divider cell lost a stalled pixel");
`endif

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench
    import pob_pkg::*;
();

    // Cycles from an input transfer until its result is offered.
    localparam int LATENCY        = 11;
    // Cycles without any transfer before the run is declared hung. The worst
    // quiet stretch in a correct run is an input gap, the pipeline latency,
    // an output stall and a drain pause, far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 24;
    localparam int PHASE_PIXELS   = 60;
    localparam int FINAL_PIXELS   = 100;
    localparam int CORNER_PIXELS  = 8;

    // Mirror of the blend registers plus the pixels still owed by the block.
    class blend_scoreboard;
        bit [WEIGHT_W-1:0] blend_weight;
        bit [CC_W-1:0]     channel_count;
        pob_out_t          expected_pixels[$];
        int                errors;

        function new();
            blend_weight  = '0;
            channel_count = CC_ALPHA;
            errors        = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_EFFECT_WEIGHT: blend_weight  = data[WEIGHT_W-1:0];
                REG_CHANNEL_COUNT: channel_count = data[CC_W-1:0];
                default: ;
            endcase
        endfunction

        // Premultiplied lerp of the original (dst) toward the filtered (src) pixel.
        function pob_out_t blend_pixel(pob_in_t px);
            bit [63:0]      src_c[COLORS];
            bit [63:0]      dst_c[COLORS];
            bit [63:0]      sa, da, w, bw, num, prod, v;
            bit [PIX_W-1:0] mixed[COLORS];
            int             colors;
            bit             alpha_on;
            pob_out_t       r;

            src_c[0] = px.src_red;
            src_c[1] = px.src_green;
            src_c[2] = px.src_blue;
            dst_c[0] = px.dst_red;
            dst_c[1] = px.dst_green;
            dst_c[2] = px.dst_blue;
            // Counts of five and up behave as four: last channel is alpha.
            alpha_on = channel_count >= CC_ALPHA;
            colors   = (channel_count < COLORS) ? int'(channel_count) : COLORS;
            sa  = alpha_on ? 64'(px.src_alpha) : 64'(FULL_PIX);
            da  = alpha_on ? 64'(px.dst_alpha) : 64'(FULL_PIX);
            w   = blend_weight;
            bw  = 64'(WEIGHT_MAX) - w;
            num = da * bw + sa * w;

            for (int c = 0; c < COLORS; c++)
            begin
                if (c >= colors || w == 0)
                    v = dst_c[c];
                else if (w == WEIGHT_MAX)
                    v = src_c[c];
                else if (num == 0)
                    v = 0;
                else
                begin
                    prod = dst_c[c] * da * bw + src_c[c] * sa * w;
                    v    = (prod + num / 2) / num;
                    if (v > FULL_PIX)
                        v = FULL_PIX;
                end
                mixed[c] = v[PIX_W-1:0];
            end

            r.out_red   = mixed[0];
            r.out_green = mixed[1];
            r.out_blue  = mixed[2];
            if (!alpha_on)
                r.out_alpha = FULL_PIX;
            else if (w == 0)
                r.out_alpha = da[PIX_W-1:0];
            else if (w == WEIGHT_MAX)
                r.out_alpha = sa[PIX_W-1:0];
            else
            begin
                v = (num + ALPHA_ROUND) / WEIGHT_MAX;
                if (v > FULL_PIX)
                    v = FULL_PIX;
                r.out_alpha = v[PIX_W-1:0];
            end
            return r;
        endfunction

        function void note_pixel(pob_in_t px);
            expected_pixels = {expected_pixels, blend_pixel(px)};
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_pixel(pob_out_t got);
            pob_out_t want;

            if (expected_pixels.size() == 0)
            begin
                flag($sformatf("unexpected blend result r=%0d g=%0d b=%0d a=%0d",
                               got.out_red, got.out_green, got.out_blue, got.out_alpha));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha)
                flag($sformatf({"blend mismatch: expected r=%0d g=%0d b=%0d a=%0d,",
                                " got r=%0d g=%0d b=%0d a=%0d"},
                               want.out_red, want.out_green, want.out_blue, want.out_alpha,
                               got.out_red, got.out_green, got.out_blue, got.out_alpha));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    pob_in_t               in_pixel;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    pob_out_t              out_pixel;

    blend_scoreboard sb;
    // Random gaps and stalls are enabled while this is set.
    bit              idle_on = 1'b1;
    int              stall_left = 0;
    int              quiet_cycles = 0;

    premultiplied_opacity_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pixel  (in_pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel)
    );

    always #1 clk = ~clk;

    // Receiver side: a series of random runs, each one a stall or a flow.
    // Drop the stall at once when idling is switched off.
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left == 0)
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_left <= $urandom_range(0, 15);
        end
        else
            stall_left <= stall_left - 1;
    end

    // Check every result transfer against the oldest expected pixel.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_pixel(out_pixel);
    end

    // Watchdog: count cycles in which neither side completes a transfer.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mostly full range, with a strong pull toward the 0 and 255 extremes.
    function automatic logic [PIX_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FULL_PIX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pob_in_t random_pixel();
        pob_in_t px;

        px.src_red   = random_level();
        px.src_green = random_level();
        px.src_blue  = random_level();
        px.src_alpha = random_level();
        px.dst_red   = random_level();
        px.dst_green = random_level();
        px.dst_blue  = random_level();
        px.dst_alpha = random_level();
        // Force a zero alpha numerator now and then.
        if ($urandom_range(0, 15) == 0)
        begin
            px.src_alpha = '0;
            px.dst_alpha = '0;
        end
        return px;
    endfunction

    // Hand-picked pixels: extremes, transparent source or original, and
    // both alphas zero.
    function automatic pob_in_t corner_pixel(int k);
        pob_in_t px;

        px = random_pixel();
        case (k)
            0: px = '0;
            1: px = '1;
            2: px.src_alpha = '0;
            3: px.dst_alpha = '0;
            4: px = {{3{FULL_PIX}}, 8'h00, {3{FULL_PIX}}, 8'h00};
            5: px = {{4{FULL_PIX}}, {4{8'h00}}};
            6: px = {{3{8'h00}}, FULL_PIX, {4{FULL_PIX}}};
            default: px = {{4{8'hAA}}, {4{8'h55}}};
        endcase
        return px;
    endfunction

    // Offer one pixel, optionally after a random gap, and hold it until the
    // transfer completes. Leave valid high so back-to-back pixels stream.
    task automatic send_pixel(input pob_in_t px);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_pixel <= px;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_pixel(px);
    endtask

    task automatic send_pixels(input int count, input bit corners);
        for (int i = 0; i < count; i++)
            send_pixel(corners ? corner_pixel(i) : random_pixel());
        in_valid <= 1'b0;
    endtask

    // Wait for every owed result, then let the pipeline settle.
    task automatic drain_pipeline();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);
    endtask

    // Write both registers on consecutive edges; keep write enable high across.
    task automatic set_blend(input logic [WEIGHT_W-1:0] weight, input logic [CC_W-1:0] count);
        cfg_write <= 1'b1;
        cfg_index <= REG_EFFECT_WEIGHT;
        cfg_data  <= weight;
        @(posedge clk);
        sb.write_reg(REG_EFFECT_WEIGHT, weight);
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        sb.write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(count));
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input logic [WEIGHT_W-1:0] weight, input logic [CC_W-1:0] count,
                             input int pixels, input bit corners);
        drain_pipeline();
        set_blend(weight, count);
        send_pixels(pixels, corners);
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight(int phase);
        case (phase)
            0: return 16'd1;
            1: return WEIGHT_MAX - 1'b1;
            2: return '0;
            3: return WEIGHT_MAX;
            default:
                case ($urandom_range(0, 7))
                    0:       return '0;
                    1:       return WEIGHT_MAX;
                    2:       return 16'd1;
                    3:       return WEIGHT_MAX - 1'b1;
                    default: return WEIGHT_W'($urandom_range(0, 65535));
                endcase
        endcase
    endfunction

    // Sweep every channel count once, then favor the four-channel case.
    function automatic logic [CC_W-1:0] pick_count(int phase);
        if (phase < 8)
            return CC_W'(phase);
        if ($urandom_range(0, 1) == 0)
            return CC_ALPHA;
        return CC_W'($urandom_range(0, 7));
    endfunction

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_EFFECT_WEIGHT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_pixel  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner pixels: first with the reset setting (weight zero, four
        // channels), then at full weight and at half weight.
        send_pixels(CORNER_PIXELS, 1'b1);
        run_phase(WEIGHT_MAX, CC_ALPHA, CORNER_PIXELS, 1'b1);
        run_phase(16'h8000, CC_ALPHA, CORNER_PIXELS, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_phase(pick_weight(p), pick_count(p), PHASE_PIXELS, 1'b0);

        // Closing stretch at full rate: no gaps, no stalls.
        drain_pipeline();
        idle_on = 1'b0;
        run_phase(WEIGHT_W'($urandom_range(1, 65534)), CC_ALPHA, FINAL_PIXELS, 1'b0);

        drain_pipeline();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
